[hw/rtl/qrr_pkg.sv]
// ----------------------------------------------------------------------------
// qrr_pkg - shared types and constants of the four-queue merge
// Command format between front and back, opcode, status and heading codes.
// ----------------------------------------------------------------------------
package qrr_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int NUM_QUEUES      = 4;

	// input opcodes
	localparam logic [1:0] OP_SET   = 2'd0;
	localparam logic [1:0] OP_ENQ   = 2'd1;
	localparam logic [1:0] OP_DRAIN = 2'd2;

	// result status codes
	localparam logic [1:0] ST_PLANE = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// heading codes
	localparam logic [2:0] HD_NONE  = 3'd0;
	localparam logic [2:0] HD_WEST  = 3'd1;
	localparam logic [2:0] HD_SOUTH = 3'd2;
	localparam logic [2:0] HD_NORTH = 3'd3;
	localparam logic [2:0] HD_EAST  = 3'd4;

	typedef enum logic [1:0] {
		CMD_SET,
		CMD_ENQ,
		CMD_DRAIN
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [2:0]  heading;
		logic [31:0] text;
	} cmd_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] idx;
	} queue_sel_t;

	// queues are visited west, north, south, east
	function automatic queue_sel_t heading_to_queue(input logic [2:0] code);
		queue_sel_t sel;
		sel = '0;
		unique case (code)
			HD_WEST:  sel = '{valid: 1'b1, idx: 2'd0};
			HD_NORTH: sel = '{valid: 1'b1, idx: 2'd1};
			HD_SOUTH: sel = '{valid: 1'b1, idx: 2'd2};
			HD_EAST:  sel = '{valid: 1'b1, idx: 2'd3};
			default:  sel = '0;
		endcase
		return sel;
	endfunction

	function automatic logic [2:0] queue_to_heading(input logic [1:0] idx);
		logic [2:0] code;
		code = HD_NONE;
		unique case (idx)
			2'd0:    code = HD_WEST;
			2'd1:    code = HD_NORTH;
			2'd2:    code = HD_SOUTH;
			default: code = HD_EAST;
		endcase
		return code;
	endfunction

endpackage

[hw/rtl/qrr_front.sv]
// ----------------------------------------------------------------------------
// qrr_front - input decode and command queue
// Accepts input beats, turns them into commands and holds up to two of them
// for the back end; unused opcodes are taken and dropped.
// ----------------------------------------------------------------------------
module qrr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        in_opcode,
	input  logic [2:0]        in_heading,
	input  logic [31:0]       in_text,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output qrr_pkg::cmd_t     cmd
);

	qrr_pkg::cmd_t cmd_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    fill_q;

	qrr_pkg::cmd_t dec_cmd;
	logic          dec_ok;
	logic          push;
	logic          pop;

	always_comb begin
		dec_ok          = 1'b1;
		dec_cmd.kind    = qrr_pkg::CMD_SET;
		dec_cmd.heading = in_heading;
		dec_cmd.text    = in_text;
		unique case (in_opcode)
			qrr_pkg::OP_SET:   dec_cmd.kind = qrr_pkg::CMD_SET;
			qrr_pkg::OP_ENQ:   dec_cmd.kind = qrr_pkg::CMD_ENQ;
			qrr_pkg::OP_DRAIN: dec_cmd.kind = qrr_pkg::CMD_DRAIN;
			default:           dec_ok = 1'b0;
		endcase
	end

	assign in_ready  = (fill_q != 2'd2);
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = cmd_q[rd_ptr_q];
	assign push      = in_valid && in_ready && dec_ok;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			cmd_q[wr_ptr_q] <= dec_cmd;
	end

endmodule

[hw/rtl/qrr_back.sv]
// ----------------------------------------------------------------------------
// qrr_back - queue store, heading state and drain sequencer
// Runs commands from the front: heading updates, appends into the shared
// plane store and the round-robin drain through a one-beat output register.
// ----------------------------------------------------------------------------
module qrr_back #(
	parameter int QUEUE_DEPTH = qrr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  qrr_pkg::cmd_t cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   out_plane,
	output logic [2:0]    out_heading,
	output logic [1:0]    out_status,
	output logic          out_last
);

	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int DEPTH = qrr_pkg::NUM_QUEUES * QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_LOAD
	} state_t;

	state_t      state_q;
	logic [CW-1:0] count_q [qrr_pkg::NUM_QUEUES];
	logic [2:0]  heading_q;
	logic [CW-1:0] round_q;
	logic [1:0]  qsel_q;
	logic        pend_last_q;
	logic        out_valid_q;
	logic [31:0] out_plane_q;
	logic [2:0]  out_heading_q;
	logic [1:0]  out_status_q;
	logic        out_last_q;

	logic [31:0] store_q [DEPTH];
	logic [31:0] rd_data_q;

	logic          out_free;
	logic          out_load;
	logic [CW-1:0] max_cnt;
	logic          later_any;
	logic          scan_last;
	logic          scan_hit;
	logic          scan_done;
	qrr_pkg::queue_sel_t enq_sel;
	qrr_pkg::queue_sel_t set_sel;
	logic          enq_full;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;

	assign out_free = !out_valid_q || out_ready;
	assign enq_sel  = qrr_pkg::heading_to_queue(heading_q);
	assign set_sel  = qrr_pkg::heading_to_queue(cmd.heading);
	assign enq_full = (count_q[enq_sel.idx] == CW'(QUEUE_DEPTH));

	always_comb begin
		max_cnt   = '0;
		later_any = 1'b0;
		for (int q = 0; q < qrr_pkg::NUM_QUEUES; q++) begin
			if (count_q[q] > max_cnt)
				max_cnt = count_q[q];
			if (2'(q) > qsel_q && count_q[q] > round_q)
				later_any = 1'b1;
		end
	end

	assign scan_done = (round_q >= max_cnt);
	assign scan_hit  = (count_q[qsel_q] > round_q);
	// last plane: no later round and no later queue in this round holds one
	assign scan_last = ((round_q + CW'(1)) >= max_cnt) && !later_any;

	always_comb begin
		cmd_ready = 1'b0;
		if (state_q == S_IDLE && cmd_valid) begin
			cmd_ready = 1'b1;
			if (cmd.kind == qrr_pkg::CMD_ENQ && enq_sel.valid && enq_full)
				cmd_ready = out_free;
		end
	end

	// a new beat enters the output register this cycle
	assign out_load = ((state_q == S_IDLE) && cmd_valid && cmd.kind == qrr_pkg::CMD_ENQ
			&& enq_sel.valid && enq_full && out_free)
		|| ((state_q == S_SCAN) && scan_done && max_cnt == '0 && out_free)
		|| ((state_q == S_LOAD) && out_free);

	assign mem_we    = (state_q == S_IDLE) && cmd_valid && cmd.kind == qrr_pkg::CMD_ENQ
		&& enq_sel.valid && !enq_full;
	assign mem_waddr = AW'(enq_sel.idx) * AW'(QUEUE_DEPTH) + AW'(count_q[enq_sel.idx]);
	assign mem_re    = (state_q == S_SCAN) && !scan_done && scan_hit;
	assign mem_raddr = AW'(qsel_q) * AW'(QUEUE_DEPTH) + AW'(round_q);

	always_ff @(posedge clk) begin
		if (mem_we)
			store_q[mem_waddr] <= cmd.text;
		if (mem_re)
			rd_data_q <= store_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			heading_q   <= qrr_pkg::HD_NONE;
			round_q     <= '0;
			qsel_q      <= 2'd0;
			pend_last_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_plane_q   <= '0;
			out_heading_q <= qrr_pkg::HD_NONE;
			out_status_q  <= qrr_pkg::ST_PLANE;
			out_last_q    <= 1'b0;
			for (int q = 0; q < qrr_pkg::NUM_QUEUES; q++)
				count_q[q] <= '0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.kind)
							qrr_pkg::CMD_SET: begin
								heading_q <= set_sel.valid ?
									cmd.heading : qrr_pkg::HD_NONE;
							end
							qrr_pkg::CMD_ENQ: begin
								if (enq_sel.valid && !enq_full) begin
									count_q[enq_sel.idx] <= count_q[enq_sel.idx] + CW'(1);
								end else if (enq_sel.valid && out_free) begin
									out_plane_q   <= cmd.text;
									out_heading_q <= heading_q;
									out_status_q  <= qrr_pkg::ST_FULL;
									out_last_q    <= 1'b1;
								end
							end
							qrr_pkg::CMD_DRAIN: begin
								round_q <= '0;
								qsel_q  <= 2'd0;
								state_q <= S_SCAN;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						if (max_cnt != '0 || out_free) begin
							if (max_cnt == '0) begin
								out_plane_q   <= '0;
								out_heading_q <= qrr_pkg::HD_NONE;
								out_status_q  <= qrr_pkg::ST_EMPTY;
								out_last_q    <= 1'b1;
							end
							for (int q = 0; q < qrr_pkg::NUM_QUEUES; q++)
								count_q[q] <= '0;
							heading_q <= qrr_pkg::HD_NONE;
							state_q   <= S_IDLE;
						end
					end else if (scan_hit) begin
						pend_last_q <= scan_last;
						state_q     <= S_LOAD;
					end else begin
						qsel_q <= qsel_q + 2'd1;
						if (qsel_q == 2'd3)
							round_q <= round_q + CW'(1);
					end
				end
				S_LOAD: begin
					if (out_free) begin
						out_plane_q   <= rd_data_q;
						out_heading_q <= qrr_pkg::queue_to_heading(qsel_q);
						out_status_q  <= qrr_pkg::ST_PLANE;
						out_last_q    <= pend_last_q;
						qsel_q        <= qsel_q + 2'd1;
						if (qsel_q == 2'd3)
							round_q <= round_q + CW'(1);
						state_q <= S_SCAN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_plane   = out_plane_q;
	assign out_heading = out_heading_q;
	assign out_status  = out_status_q;
	assign out_last    = out_last_q;

endmodule

[hw/rtl/four_queue_round_robin_merge.sv]
// order: set and enqueue take effect once the back end takes them from the command queue;
// a full-queue enqueue result is loaded as the enqueue is taken, an empty drain result from
// scan, and each drained plane is read in scan, after any empty slots, and sent from load
// throughput: one set or enqueue per cycle when idle (a full-queue enqueue also needs out_free);
// a drain reads its planes from the store read port one queue slot at a time, empty ones too
// reset: arst_n clears queues, heading and both handshakes; plane storage needs no clearing
// ----------------------------------------------------------------------------
// four_queue_round_robin_merge - four heading queues merged round robin
// Items set a heading, append planes to that heading's queue, or drain all
// queues west, north, south, east in turn with the final beat marked.
// ----------------------------------------------------------------------------
module four_queue_round_robin_merge #(
	parameter int QUEUE_DEPTH = qrr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // heading_code[2:0], plane_text[34:3], zero pad
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // plane_out[31:0], from_heading[34:32], zero pad
	output logic [1:0]  m_tuser,   // status[1:0]
	output logic        m_tlast
);

	logic          cmd_valid;
	logic          cmd_ready;
	qrr_pkg::cmd_t cmd;
	logic [31:0]   plane_out;
	logic [2:0]    from_heading;

	qrr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_opcode  (s_tuser),
		.in_heading (s_tdata[2:0]),
		.in_text    (s_tdata[34:3]),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd)
	);

	qrr_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_plane   (plane_out),
		.out_heading (from_heading),
		.out_status  (m_tuser),
		.out_last    (m_tlast)
	);

	assign m_tdata = {5'd0, from_heading, plane_out};

`ifndef SYNTHESIS
	// input stalls only while the command queue is holding work
	a_stall_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> cmd_valid)
		else $error("input stalled with empty command queue");

	// status results stand alone and always close their item
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != qrr_pkg::ST_PLANE |-> m_tlast)
		else $error("status result without last");

	// an empty drain carries no plane and no heading
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == qrr_pkg::ST_EMPTY |-> m_tdata == 40'd0)
		else $error("empty drain result carries data");
`endif

endmodule

[tb/sv/qrr_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qrr_checker - result predictor and scoreboard for the four-queue merge
// Watches both stream channels, keeps its own copy of the heading queues,
// works out the beats that each accepted item causes and compares them in order.
// ----------------------------------------------------------------------------
module qrr_checker #(
	parameter int QUEUE_DEPTH = qrr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // heading_code[2:0], plane_text[34:3], zero pad
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // plane_out[31:0], from_heading[34:32], zero pad
	input  logic [1:0]  m_tuser,   // status[1:0]
	input  logic        m_tlast,
	output int          error_count,
	output int          pending_beats
);
	import qrr_pkg::*;

	typedef struct packed {
		logic [31:0] plane;
		logic [2:0]  heading;
		logic [1:0]  status;
		logic        last;
	} merge_beat_t;

	// drain visits the queues in this order
	localparam logic [2:0] DRAIN_ORDER [NUM_QUEUES] = '{HD_WEST, HD_NORTH, HD_SOUTH, HD_EAST};

	merge_beat_t expected_beats[$];
	logic [31:0] heading_fifo[NUM_QUEUES][$];
	logic [2:0]  cur_heading;

	function automatic int slot_of_heading(input logic [2:0] code);
		case (code)
			HD_WEST:  return 0;
			HD_NORTH: return 1;
			HD_SOUTH: return 2;
			HD_EAST:  return 3;
			default:  return -1;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s got %0h expected %0h", $time, what, got, want);
		error_count++;
	endtask

	task automatic merge_item(input logic [1:0] op, input logic [2:0] code,
			input logic [31:0] text);
		int slot;
		int produced;
		bit found;
		merge_beat_t beat;
		case (op)
			OP_SET: begin
				cur_heading = (slot_of_heading(code) >= 0) ? code : HD_NONE;
			end
			OP_ENQ: begin
				slot = slot_of_heading(cur_heading);
				// no heading: plane is dropped without a beat
				if (slot >= 0) begin
					if (heading_fifo[slot].size() >= QUEUE_DEPTH) begin
						beat.plane   = text;
						beat.heading = cur_heading;
						beat.status  = ST_FULL;
						beat.last    = 1'b1;
						expected_beats.push_back(beat);
					end else begin
						heading_fifo[slot].push_back(text);
					end
				end
			end
			OP_DRAIN: begin
				produced = 0;
				do begin
					found = 1'b0;
					for (int i = 0; i < NUM_QUEUES; i++) begin
						if (heading_fifo[i].size() != 0) begin
							beat.plane   = heading_fifo[i].pop_front();
							beat.heading = DRAIN_ORDER[i];
							beat.status  = ST_PLANE;
							beat.last    = 1'b0;
							expected_beats.push_back(beat);
							produced++;
							found = 1'b1;
						end
					end
				end while (found);
				if (produced == 0) begin
					beat.plane   = '0;
					beat.heading = HD_NONE;
					beat.status  = ST_EMPTY;
					beat.last    = 1'b1;
					expected_beats.push_back(beat);
				end else begin
					expected_beats[expected_beats.size() - 1].last = 1'b1;
				end
				cur_heading = HD_NONE;
			end
			default: ;
		endcase
	endtask

	task automatic check_beat();
		merge_beat_t want;
		if (expected_beats.size() == 0) begin
			report_mismatch("unexpected result beat, plane", m_tdata[31:0], '0);
			return;
		end
		want = expected_beats.pop_front();
		if (m_tdata[31:0] !== want.plane)
			report_mismatch("plane_out", m_tdata[31:0], want.plane);
		if (m_tdata[34:32] !== want.heading)
			report_mismatch("from_heading", m_tdata[34:32], want.heading);
		if (m_tuser !== want.status)
			report_mismatch("status", m_tuser, want.status);
		if (m_tlast !== want.last)
			report_mismatch("last", m_tlast, want.last);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_beats.delete();
			for (int i = 0; i < NUM_QUEUES; i++)
				heading_fifo[i].delete();
			cur_heading = HD_NONE;
			pending_beats = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_beat();
			if (s_tvalid && s_tready)
				merge_item(s_tuser, s_tdata[2:0], s_tdata[34:3]);
			pending_beats = expected_beats.size();
		end
	end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - stream testbench of the four-queue round-robin merge
// Drives directed and random heading, enqueue, drain and unused items with random gaps
// and back-pressure, including one long output stall; the checker scores beats.
// ----------------------------------------------------------------------------
module tb;
	import qrr_pkg::*;

	localparam int         DEPTH       = QUEUE_DEPTH_DEF;
	localparam int         HOLD_CYCLES = 400;
	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam logic [2:0] HD_BAD      = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	int error_count;
	int pending_beats;
	int send_idle_pct = 35;
	int recv_idle_pct = 53;
	int items_sent = 0;
	bit hold_go = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	four_queue_round_robin_merge #(.QUEUE_DEPTH(DEPTH)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	qrr_checker #(.QUEUE_DEPTH(DEPTH)) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.error_count   (error_count),
		.pending_beats (pending_beats)
	);

	function automatic logic [31:0] random_text();
		case ($urandom_range(0, 9))
			0:       return 32'h0000_0000;
			1:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] random_heading();
		case ($urandom_range(0, 3))
			0:       return HD_WEST;
			1:       return HD_NORTH;
			2:       return HD_SOUTH;
			default: return HD_EAST;
		endcase
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [2:0] code,
			input logic [31:0] text);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {5'b0, text, code};
		do @(posedge clk); while (!s_tready);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	task automatic enqueue_burst(input int n);
		repeat (n) send_item(OP_ENQ, 3'($urandom_range(0, 7)), random_text());
	endtask

	task automatic random_sequence();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			// mostly short bursts, now and then enough to overflow a queue
			n = ($urandom_range(0, 7) == 0) ? DEPTH + $urandom_range(1, 3) : $urandom_range(1, 5);
			send_item(OP_SET, random_heading(), random_text());
			enqueue_burst(n);
		end else if (pick < 78) begin
			send_item(OP_DRAIN, 3'($urandom_range(0, 7)), random_text());
		end else if (pick < 88) begin
			send_item(OP_SET, 3'($urandom_range(0, 7)), random_text());
			enqueue_burst($urandom_range(1, 2));
		end else if (pick < 94) begin
			send_item(OP_UNUSED, 3'($urandom_range(0, 7)), random_text());
		end else begin
			// heading is cleared by the drain, so the plane after it goes nowhere
			send_item(OP_DRAIN, 3'($urandom_range(0, 7)), random_text());
			enqueue_burst(1);
		end
	endtask

	task automatic run_random(input int upto);
		while (items_sent < upto) random_sequence();
	endtask

	// receiver: random back-pressure, or one long hold-off when asked
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= OP_SET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_DRAIN, HD_NONE, '0);
		send_item(OP_UNUSED, HD_BAD, 32'hffff_ffff);
		send_item(OP_SET, HD_BAD, 32'hffff_ffff);
		send_item(OP_ENQ, HD_NONE, 32'h4131_2d33);
		send_item(OP_SET, HD_WEST, '0);
		send_item(OP_ENQ, HD_NONE, 32'h0000_0000);
		send_item(OP_ENQ, HD_BAD, 32'hffff_ffff);
		send_item(OP_SET, HD_NORTH, '0);
		send_item(OP_ENQ, HD_NONE, 32'h4132_2d33);
		send_item(OP_SET, HD_SOUTH, '0);
		send_item(OP_ENQ, HD_NONE, 32'h4133_2d32);
		send_item(OP_SET, HD_EAST, '0);
		send_item(OP_ENQ, HD_NONE, 32'h4134_2d34);
		send_item(OP_DRAIN, HD_BAD, 32'hffff_ffff);

		run_random(65);
		send_idle_pct = 53;
		recv_idle_pct = 35;
		run_random(115);
		send_idle_pct = 0;
		recv_idle_pct = 0;

		// long output stall behind a drain, then an overflowing burst
		send_item(OP_SET, HD_WEST, random_text());
		enqueue_burst(6);
		send_item(OP_SET, HD_EAST, random_text());
		enqueue_burst(6);
		hold_go = 1'b1;
		send_item(OP_DRAIN, 3'($urandom_range(0, 7)), random_text());
		send_item(OP_SET, HD_NORTH, random_text());
		enqueue_burst(DEPTH + 2);
		send_item(OP_DRAIN, 3'($urandom_range(0, 7)), random_text());

		run_random(170);
		s_tvalid <= 1'b0;

		// let the checker take in the final beat before waiting on it
		@(posedge clk);
		for (int c = 0; c < 50_000 && pending_beats != 0; c++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0 && pending_beats == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
